[sv/assert_macros.svh]
// assertion helpers, compiled out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property checked on every rising clk edge outside reset
`define PTT_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("ptt assertion failed");

// condition that must never be true
`define PTT_NEVER(label, expr) \
    `PTT_ASSERT(label, !(expr))

`else

`define PTT_ASSERT(label, prop)
`define PTT_NEVER(label, expr)

`endif

`endif

[sv/ptt_pkg.sv]
package ptt_pkg;

    localparam int CHAN_W   = 8;
    localparam int TIME_W   = 63;
    localparam int PERIOD_W = 15;
    localparam int KIND_W   = 3;

    localparam logic [KIND_W-1:0] KIND_TIME      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ERROR     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_OVF_BEGIN = 3'd2;
    localparam logic [KIND_W-1:0] KIND_OVF_END   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_MISSED    = 3'd4;

    localparam logic REG_LASER_CH = 1'b0;
    localparam logic REG_PERIOD   = 1'b1;

    localparam logic signed [CHAN_W-1:0] LASER_CH_RESET = 8'sd1;
    localparam logic [PERIOD_W-1:0]      PERIOD_RESET   = 15'd12500;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;

    localparam int DIV_STEPS = TIME_W;
    localparam int DIV_CNT_W = 6;

    typedef struct packed {
        logic signed [CHAN_W-1:0] channel;
        logic [TIME_W-1:0]        time_ps;
        logic [TIME_W-1:0]        diff;
        logic                     err;
    } job_t;

endpackage

[sv/photon_micro_time_tagger_top.sv]
// channel   direction  handshake               payload
// tag in    input      in_valid / in_ready     tag_kind, tag_channel, tag_time_ps
// record    output     out_valid / out_ready   photon_channel, macro_time_ps,
//                                              micro_time_ps, error_seen
// config    input      apb psel/penable/pwrite paddr, pwdata, prdata, pready
//
// laser, error and ignored tags are handled at the input and not queued; a photon is queued (4 deep)
// the remainder unit loads one queued photon and then works its remainder out one
// dividend bit at a time, msb first, and takes the next photon once the record is
// loaded; in_ready drops only while the photon queue is full; a stalled record waits in
// the output register while the next remainder runs
// rst_n clears the laser time, error flag, queue and config to reset values
module photon_micro_time_tagger_top
    import ptt_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [KIND_W-1:0]          tag_kind,
    input  logic signed [CHAN_W-1:0]   tag_channel,
    input  logic [TIME_W-1:0]          tag_time_ps,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [CHAN_W-1:0]   photon_channel,
    output logic [TIME_W-1:0]          macro_time_ps,
    output logic [PERIOD_W-1:0]        micro_time_ps,
    output logic                       error_seen,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    logic signed [CHAN_W-1:0] laser_ch_reg;
    logic [PERIOD_W-1:0]      period_reg;
    logic                     cfg_wr;
    logic                     push_valid;
    logic                     fifo_full;
    logic                     fifo_not_empty;
    logic                     job_pop;
    job_t                     push_job;
    job_t                     pop_job;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            laser_ch_reg <= LASER_CH_RESET;
            period_reg   <= PERIOD_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_LASER_CH)
            begin
                laser_ch_reg <= pwdata[CHAN_W-1:0];
            end
            else
            begin
                period_reg <= pwdata[PERIOD_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_PERIOD) ? {17'b0, period_reg} : {24'b0, laser_ch_reg};

    ptt_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .tag_kind    (tag_kind),
        .tag_channel (tag_channel),
        .tag_time_ps (tag_time_ps),
        .laser_ch    (laser_ch_reg),
        .push_valid  (push_valid),
        .push_ready  (!fifo_full),
        .push_job    (push_job)
    );

    ptt_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push_valid),
        .push_job  (push_job),
        .full      (fifo_full),
        .pop       (job_pop),
        .not_empty (fifo_not_empty),
        .pop_job   (pop_job)
    );

    ptt_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .period         (period_reg),
        .job_valid      (fifo_not_empty),
        .job            (pop_job),
        .job_pop        (job_pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .photon_channel (photon_channel),
        .macro_time_ps  (macro_time_ps),
        .micro_time_ps  (micro_time_ps),
        .error_seen     (error_seen)
    );

endmodule

[sv/ptt_front.sv]
module ptt_front
    import ptt_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [KIND_W-1:0]          tag_kind,
    input  logic signed [CHAN_W-1:0]   tag_channel,
    input  logic [TIME_W-1:0]          tag_time_ps,
    input  logic signed [CHAN_W-1:0]   laser_ch,
    output logic                       push_valid,
    input  logic                       push_ready,
    output job_t                       push_job
);

    logic [TIME_W-1:0] last_laser_reg;
    logic [TIME_W-1:0] last_laser_next;
    logic              err_reg;
    logic              err_next;
    logic              accept;
    logic              is_err_kind;
    logic              is_laser;
    logic              is_photon;

    assign in_ready = push_ready;
    assign accept   = in_valid && in_ready;

    assign is_err_kind = (tag_kind == KIND_ERROR) || (tag_kind == KIND_OVF_BEGIN) ||
                         (tag_kind == KIND_OVF_END) || (tag_kind == KIND_MISSED);
    assign is_laser    = (tag_kind == KIND_TIME) && (tag_channel == laser_ch);
    // no record until a nonzero laser time is stored
    assign is_photon   = (tag_kind == KIND_TIME) && (tag_channel != laser_ch) &&
                         (last_laser_reg != '0);

    always_comb
    begin
        last_laser_next = last_laser_reg;
        err_next        = err_reg;
        if (accept && is_err_kind)
        begin
            err_next = 1'b1;
        end
        if (accept && is_laser)
        begin
            last_laser_next = tag_time_ps;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_laser_reg <= '0;
            err_reg        <= 1'b0;
        end
        else
        begin
            last_laser_reg <= last_laser_next;
            err_reg        <= err_next;
        end
    end

    assign push_valid = in_valid && is_photon;

    always_comb
    begin
        push_job.channel = tag_channel;
        push_job.time_ps = tag_time_ps;
        // photon ahead of the laser clamps to zero
        push_job.diff    = (tag_time_ps >= last_laser_reg) ?
                           (tag_time_ps - last_laser_reg) : '0;
        push_job.err     = err_reg;
    end

endmodule

[sv/ptt_fifo.sv]
`include "assert_macros.svh"

module ptt_fifo
    import ptt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output job_t pop_job
);

    localparam logic [FIFO_PTR_W:0] DEPTH_C = (FIFO_PTR_W + 1)'(FIFO_DEPTH);

    job_t                  mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W:0]   count_reg;
    logic [FIFO_PTR_W:0]   count_next;
    logic                  do_push;
    logic                  do_pop;

    assign full      = (count_reg == DEPTH_C);
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_job   = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    `PTT_NEVER(a_fifo_overfill, count_reg > DEPTH_C)
    `PTT_ASSERT(a_fifo_ptr_gap, (wr_ptr_reg - rd_ptr_reg) == count_reg[FIFO_PTR_W-1:0])

endmodule

[sv/ptt_back.sv]
`include "assert_macros.svh"

module ptt_back
    import ptt_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [PERIOD_W-1:0]        period,
    input  logic                       job_valid,
    input  job_t                       job,
    output logic                       job_pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [CHAN_W-1:0]   photon_channel,
    output logic [TIME_W-1:0]          macro_time_ps,
    output logic [PERIOD_W-1:0]        micro_time_ps,
    output logic                       error_seen
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    logic [1:0]                state_reg;
    logic [1:0]                state_next;
    logic [DIV_CNT_W-1:0]      cnt_reg;
    logic [DIV_CNT_W-1:0]      cnt_next;
    logic [PERIOD_W-1:0]       rem_reg;
    logic [TIME_W-1:0]         dividend_reg;
    logic signed [CHAN_W-1:0]  chan_reg;
    logic [TIME_W-1:0]         time_reg;
    logic                      err_reg;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic                      load_out;
    logic [PERIOD_W:0]         shifted;
    logic [PERIOD_W:0]         period_ext;
    logic [PERIOD_W-1:0]       rem_step;

    // one restoring remainder step per cycle, msb first
    assign shifted    = {rem_reg, dividend_reg[TIME_W-1]};
    assign period_ext = {1'b0, period};
    assign rem_step   = (shifted >= period_ext) ? PERIOD_W'(shifted - period_ext)
                                                : shifted[PERIOD_W-1:0];

    assign job_pop  = (state_reg == ST_IDLE) && job_valid;
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = ST_DIV;
                    cnt_next   = CNT_LAST;
                end
            end
            ST_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            rem_reg      <= '0;
            dividend_reg <= job.diff;
            chan_reg     <= job.channel;
            time_reg     <= job.time_ps;
            err_reg      <= job.err;
        end
        else if (state_reg == ST_DIV)
        begin
            rem_reg      <= rem_step;
            dividend_reg <= {dividend_reg[TIME_W-2:0], 1'b0};
        end
        if (load_out)
        begin
            photon_channel <= chan_reg;
            macro_time_ps  <= time_reg;
            micro_time_ps  <= (period == '0) ? '0 : rem_reg;
            error_seen     <= err_reg;
        end
    end

    assign out_valid = out_valid_reg;

    `PTT_ASSERT(a_back_start, (state_reg == ST_IDLE && job_valid) |=> (state_reg == ST_DIV))
    `PTT_ASSERT(a_back_finish, (state_reg == ST_DIV && cnt_reg == '0) |=> (state_reg == ST_DONE))

endmodule
